### sv/sppr_pkg.sv
`timescale 1ns / 1ps
// Package for the sample pair packetizer ring: sizes, codes, beat payload types.
// No dependencies.
package sppr_pkg;

	// Block sizes
	localparam int SLOTS          = 8;
	localparam int PACKET_BYTES   = 512;
	localparam int HEADER_BYTES   = 8;
	localparam int TAIL_MARGIN    = 16;
	localparam int WORDS_PER_SLOT = (PACKET_BYTES + 3) / 4;
	localparam int DONE_OFFSET    = (((PACKET_BYTES - TAIL_MARGIN) / 8) + 1) * 8;
	localparam int PACKET_LEN     = DONE_OFFSET + HEADER_BYTES;
	localparam int PAIRS          = DONE_OFFSET / 8;
	// sample rows per slot, row 0 is the header row
	localparam int ROWS_PER_SLOT  = (WORDS_PER_SLOT + 1) / 2;

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int COUNT_W = $clog2(SLOTS + 1);
	localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int ROW_W   = $clog2(ROWS_PER_SLOT);
	localparam int ADDR_W  = SLOT_W + ROW_W;
	localparam int BANK_DEPTH = SLOTS << ROW_W;

	localparam logic [PAIR_W-1:0]  PAIR_LAST = PAIR_W'(PAIRS - 1);
	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(SLOTS);
	localparam logic [31:0] HEADER_WORD = 32'h0000_5444; // 'D', 'T'

	// Action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DONE   = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	// Endpoint commands
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_ACK  = 2'd1;
	localparam logic [1:0] CMD_NAK  = 2'd2;

	localparam logic [9:0] SEND_LEN = 10'(PACKET_LEN);

	// Source of the read data word in the result stage
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_HEADER,
		RD_EVEN,
		RD_ODD
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] sample_first;
		logic [31:0] sample_second;
		logic [2:0]  read_slot;
		logic [6:0]  read_word;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  endpoint_command;
		logic [2:0]  send_slot;
		logic [9:0]  send_length;
		logic [3:0]  queued_packets;
		logic [31:0] read_data;
	} out_beat_t;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage

### sv/sppr_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying input beats of the packetizer.
// Depends on sppr_pkg.
interface sppr_in_if;
	logic               valid;
	logic               ready;
	sppr_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/sppr_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying result beats of the packetizer.
// Depends on sppr_pkg.
interface sppr_out_if;
	logic                valid;
	logic                ready;
	sppr_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/sample_pair_packetizer_ring_top.sv
`timescale 1ns / 1ps
// Top level of the sample pair packetizer ring: pointers, packet store, result register.
// Depends on sppr_pkg, sppr_in_if, sppr_out_if.

// Sample pair packetizer. Every input beat (insert a pair, transmit done, read a word,
// or no-op) yields exactly one result beat, registered when the beat is accepted. The block
// takes one beat per clock: a beat is accepted whenever the result register is empty
// or its beat is taken in the same cycle, so throughput is one item per cycle and only
// output back-pressure slows it. All pointer updates happen at the accept edge, and the
// packet store is two dual-port banks (even and odd words) written once and read once
// per cycle; the read lands in the result register together with the other fields.
// Packets are PACKET_LEN bytes: a fixed 'DT' header word, a zero timestamp word and
// PAIRS sample pairs. Header words are not stored; reads of words 0 and 1 return them
// from constants. No clearing pass is needed after reset.
module sample_pair_packetizer_ring_top (
	input  logic       clk,
	input  logic       arst_n,
	sppr_in_if.sink    sample_in,
	sppr_out_if.source result_out
);

	// ring pointers and fill state
	logic [sppr_pkg::SLOT_W-1:0]  head_q, head_d;
	logic [sppr_pkg::SLOT_W-1:0]  tail_q, tail_d;
	logic [sppr_pkg::COUNT_W-1:0] count_q, count_d;
	logic [sppr_pkg::PAIR_W-1:0]  pair_q, pair_d;

	// result register
	logic                 out_valid_q;
	logic [1:0]           status_q, status_d;
	logic [1:0]           cmd_q, cmd_d;
	logic [2:0]           sslot_q, sslot_d;
	logic [9:0]           slen_q, slen_d;
	sppr_pkg::rd_sel_t    rd_sel_q, rd_sel_d;
	logic [31:0]          even_rd_q, odd_rd_q;
	logic [31:0]          rdata;

	// packet store, split into even and odd word banks
	logic [31:0] even_mem [sppr_pkg::BANK_DEPTH];
	logic [31:0] odd_mem  [sppr_pkg::BANK_DEPTH];
	logic                        wr_en;
	logic [sppr_pkg::ADDR_W-1:0] wr_addr, rd_addr;

	logic                accept;
	sppr_pkg::in_beat_t beat;
	logic [sppr_pkg::SLOT_W-1:0] head_nx;

	assign beat   = sample_in.data;
	assign accept = sample_in.valid && sample_in.ready;
	assign sample_in.ready = !out_valid_q || result_out.ready;

	assign head_nx = sppr_pkg::slot_next(head_q);

	// pair n of a slot lives in row n+1; row 0 is the header row
	assign wr_addr = {tail_q, sppr_pkg::ROW_W'(pair_q) + sppr_pkg::ROW_W'(1)};
	assign rd_addr = {beat.read_slot[sppr_pkg::SLOT_W-1:0],
		beat.read_word[sppr_pkg::ROW_W:1]};

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		pair_d   = pair_q;
		status_d = sppr_pkg::ST_OK;
		cmd_d    = sppr_pkg::CMD_NONE;
		sslot_d  = 3'd0;
		slen_d   = 10'd0;
		rd_sel_d = sppr_pkg::RD_ZERO;
		wr_en    = 1'b0;
		unique case (beat.action)
			sppr_pkg::ACT_INSERT: begin
				wr_en = 1'b1;
				if (pair_q == sppr_pkg::PAIR_LAST) begin
					// packet complete: queue it, or drop it when the ring is full
					pair_d = '0;
					if (count_q == sppr_pkg::COUNT_FULL) begin
						status_d = sppr_pkg::ST_DROPPED;
					end else begin
						if (count_q == '0) begin
							cmd_d   = sppr_pkg::CMD_ACK;
							sslot_d = 3'(head_q);
							slen_d  = sppr_pkg::SEND_LEN;
						end
						count_d = count_q + sppr_pkg::COUNT_W'(1);
						tail_d  = sppr_pkg::slot_next(tail_q);
					end
				end else begin
					pair_d = pair_q + sppr_pkg::PAIR_W'(1);
				end
			end
			sppr_pkg::ACT_DONE: begin
				if (count_q == '0) begin
					status_d = sppr_pkg::ST_EMPTY;
				end else begin
					head_d  = head_nx;
					count_d = count_q - sppr_pkg::COUNT_W'(1);
					if (count_q == sppr_pkg::COUNT_W'(1)) begin
						cmd_d = sppr_pkg::CMD_NAK;
					end else begin
						cmd_d   = sppr_pkg::CMD_ACK;
						sslot_d = 3'(head_nx);
						slen_d  = sppr_pkg::SEND_LEN;
					end
				end
			end
			sppr_pkg::ACT_READ: begin
				if (int'(beat.read_slot) >= sppr_pkg::SLOTS
						|| int'(beat.read_word) >= sppr_pkg::WORDS_PER_SLOT) begin
					rd_sel_d = sppr_pkg::RD_ZERO;
				end else if (beat.read_word == 7'd0) begin
					rd_sel_d = sppr_pkg::RD_HEADER;
				end else if (beat.read_word == 7'd1) begin
					rd_sel_d = sppr_pkg::RD_ZERO; // timestamp word is always zero
				end else if (beat.read_word[0]) begin
					rd_sel_d = sppr_pkg::RD_ODD;
				end else begin
					rd_sel_d = sppr_pkg::RD_EVEN;
				end
			end
			sppr_pkg::ACT_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pair_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
				pair_q  <= pair_d;
			end
			if (sample_in.ready) begin
				out_valid_q <= sample_in.valid;
			end
		end
	end

	// result payload, held while the beat is stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			cmd_q    <= cmd_d;
			sslot_q  <= sslot_d;
			slen_q   <= slen_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	// store banks: one write and one registered read per bank per cycle
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			even_mem[wr_addr] <= beat.sample_first;
			odd_mem[wr_addr]  <= beat.sample_second;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			even_rd_q <= even_mem[rd_addr];
			odd_rd_q  <= odd_mem[rd_addr];
		end
	end

	always_comb begin
		unique case (rd_sel_q)
			sppr_pkg::RD_ZERO:   rdata = 32'd0;
			sppr_pkg::RD_HEADER: rdata = sppr_pkg::HEADER_WORD;
			sppr_pkg::RD_EVEN:   rdata = even_rd_q;
			sppr_pkg::RD_ODD:    rdata = odd_rd_q;
			default:             rdata = 32'd0;
		endcase
	end

	assign result_out.valid                 = out_valid_q;
	assign result_out.data.status           = status_q;
	assign result_out.data.endpoint_command = cmd_q;
	assign result_out.data.send_slot        = sslot_q;
	assign result_out.data.send_length      = slen_q;
	assign result_out.data.queued_packets   = 4'(count_q);
	assign result_out.data.read_data        = rdata;

endmodule

### sim/sample_pair_packetizer_ring_top_tb.sv
`timescale 1ns / 1ps
// Testbench for sample_pair_packetizer_ring_top: random and directed beats against a local
// packetizer predictor, with random idling on both channels. Depends on sppr_pkg,
// sppr_in_if, sppr_out_if and the top level.
module sample_pair_packetizer_ring_top_tb;

	localparam int STORE_WORDS    = sppr_pkg::SLOTS * sppr_pkg::WORDS_PER_SLOT;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int QUIET_TAIL     = 60;

	// one planned input beat; pick_word lets the driver aim a read at a written word
	typedef struct {
		sppr_pkg::in_beat_t beat;
		bit                 pick_word;
		bit                 hold_for_drain;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n;

	sppr_in_if  sample_in ();
	sppr_out_if result_out ();

	sample_pair_packetizer_ring_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.result_out (result_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [31:0]                 pkt_image [STORE_WORDS];
	bit                          word_seen [STORE_WORDS];
	int unsigned                 written_list [$];
	logic [sppr_pkg::SLOT_W-1:0]  head_q;
	logic [sppr_pkg::SLOT_W-1:0]  tail_q;
	logic [sppr_pkg::COUNT_W-1:0] filled_q;
	int unsigned                 fill_bytes;

	plan_t               stim_plan [$];
	sppr_pkg::out_beat_t due_results [$];

	int  beats_sent;
	int  beats_checked;
	int  errors;
	bit  quiet_tail;
	int  send_gap;
	int  stall_left;
	int  drive_idle_pct;
	int  sink_idle_pct;
	int  idle_cycles;
	int  n_ack, n_nak, n_drop, n_empty, n_read;

	plan_t               nxt;
	sppr_pkg::out_beat_t predicted;
	sppr_pkg::out_beat_t want;
	int unsigned         pick_idx;

	function automatic int idle_odds();
		int r;
		r = $urandom_range(0, 2);
		return (r == 0) ? 0 : (r == 1) ? 4 : 12;
	endfunction

	function automatic logic [31:0] sample_value();
		int r;
		r = $urandom_range(0, 9);
		return (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
	endfunction

	task automatic store_word(input logic [sppr_pkg::SLOT_W-1:0] slot, input int unsigned w,
			input logic [31:0] v);
		int unsigned idx;
		idx = int'(slot) * sppr_pkg::WORDS_PER_SLOT + w;
		if (int'(slot) < sppr_pkg::SLOTS && w < sppr_pkg::WORDS_PER_SLOT) begin
			pkt_image[idx] = v;
			if (!word_seen[idx]) begin
				word_seen[idx] = 1'b1;
				written_list.push_back(idx);
			end
		end
	endtask

	// advance the packet ring by one beat and form the result it should produce
	task automatic packetize_step(input sppr_pkg::in_beat_t b,
			output sppr_pkg::out_beat_t r);
		int unsigned w;
		r = '0;
		case (b.action)
			sppr_pkg::ACT_INSERT: begin
				if (fill_bytes == 0) begin
					store_word(tail_q, 0, sppr_pkg::HEADER_WORD);
					store_word(tail_q, 1, 32'h0);
				end
				w = (fill_bytes + sppr_pkg::HEADER_BYTES) / 4;
				store_word(tail_q, w, b.sample_first);
				store_word(tail_q, w + 1, b.sample_second);
				fill_bytes += 8;
				if (fill_bytes > sppr_pkg::PACKET_BYTES - sppr_pkg::TAIL_MARGIN) begin
					fill_bytes = 0;
					if (filled_q >= sppr_pkg::COUNT_FULL) begin
						// queue full: packet lost, tail slot reused
						r.status = sppr_pkg::ST_DROPPED;
					end else begin
						if (filled_q == 0) begin
							r.endpoint_command = sppr_pkg::CMD_ACK;
							r.send_slot        = head_q;
							r.send_length      = sppr_pkg::SEND_LEN;
						end
						filled_q = filled_q + 1'b1;
						tail_q   = sppr_pkg::SLOT_W'((int'(tail_q) + 1) % sppr_pkg::SLOTS);
					end
				end
			end
			sppr_pkg::ACT_DONE: begin
				if (filled_q == 0) begin
					r.status = sppr_pkg::ST_EMPTY;
				end else begin
					head_q   = sppr_pkg::SLOT_W'((int'(head_q) + 1) % sppr_pkg::SLOTS);
					filled_q = filled_q - 1'b1;
					if (filled_q == 0) begin
						r.endpoint_command = sppr_pkg::CMD_NAK;
					end else begin
						r.endpoint_command = sppr_pkg::CMD_ACK;
						r.send_slot        = head_q;
						r.send_length      = sppr_pkg::SEND_LEN;
					end
				end
			end
			sppr_pkg::ACT_READ: begin
				w = int'(b.read_slot) * sppr_pkg::WORDS_PER_SLOT + int'(b.read_word);
				if (int'(b.read_slot) < sppr_pkg::SLOTS
						&& int'(b.read_word) < sppr_pkg::WORDS_PER_SLOT) begin
					r.read_data = pkt_image[w];
				end
			end
			default: begin
			end
		endcase
		r.queued_packets = 4'(filled_q);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// ---- driver: presents planned beats, predicts each accepted one ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_in.valid <= 1'b0;
			sample_in.data  <= '0;
			quiet_tail      <= 1'b0;
		end else begin
			quiet_tail <= (stim_plan.size() < QUIET_TAIL);
			if (sample_in.valid && sample_in.ready) begin
				packetize_step(sample_in.data, predicted);
				due_results.push_back(predicted);
				beats_sent <= beats_sent + 1;
				if (beats_sent % 50 == 49) begin
					drive_idle_pct = idle_odds();
				end
			end
			if (!sample_in.valid || sample_in.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_in.valid <= 1'b0;
				end else if (stim_plan.size() == 0) begin
					sample_in.valid <= 1'b0;
				end else if (stim_plan[0].hold_for_drain &&
						(sample_in.valid || beats_sent != beats_checked)) begin
					// hold off until every outstanding result is back
					sample_in.valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 99) < drive_idle_pct) begin
					send_gap = $urandom_range(1, 19) - 1;
					sample_in.valid <= 1'b0;
				end else begin
					nxt = stim_plan.pop_front();
					if (nxt.pick_word) begin
						if (written_list.size() == 0) begin
							nxt.beat.action = sppr_pkg::ACT_NOP;
						end else begin
							// once more than 16 words are written, about half the reads go to the 16 newest words
							if ($urandom_range(0, 1) == 1 && written_list.size() > 16) begin
								pick_idx = written_list[written_list.size() - 1 -
									$urandom_range(0, 15)];
							end else begin
								pick_idx = written_list[$urandom_range(0,
									written_list.size() - 1)];
							end
							nxt.beat.read_slot = 3'(pick_idx / sppr_pkg::WORDS_PER_SLOT);
							nxt.beat.read_word = 7'(pick_idx % sppr_pkg::WORDS_PER_SLOT);
						end
					end
					sample_in.data  <= nxt.beat;
					sample_in.valid <= 1'b1;
				end
			end
		end
	end

	// ---- monitor: takes result beats and checks them in order ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_out.ready <= 1'b0;
		end else begin
			if (result_out.valid && result_out.ready) begin
				beats_checked <= beats_checked + 1;
				if (beats_checked % 50 == 49) begin
					sink_idle_pct = idle_odds();
				end
				if (due_results.size() == 0) begin
					$error("result beat arrived with nothing expected");
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, result_out.data.status);
					check_field("endpoint_command", want.endpoint_command,
						result_out.data.endpoint_command);
					check_field("send_slot", want.send_slot, result_out.data.send_slot);
					check_field("send_length", want.send_length, result_out.data.send_length);
					check_field("queued_packets", want.queued_packets,
						result_out.data.queued_packets);
					check_field("read_data", want.read_data, result_out.data.read_data);
					if (want.endpoint_command == sppr_pkg::CMD_ACK) n_ack++;
					if (want.endpoint_command == sppr_pkg::CMD_NAK) n_nak++;
					if (want.status == sppr_pkg::ST_DROPPED) n_drop++;
					if (want.status == sppr_pkg::ST_EMPTY) n_empty++;
					if (want.read_data != 0) n_read++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_out.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
				stall_left = $urandom_range(1, 19) - 1;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// ---- watchdog: no beat moving on either side for too long ----
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_in.valid && sample_in.ready) ||
					(result_out.valid && result_out.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ---- stimulus planning ----
	task automatic plan_beat(input sppr_pkg::in_beat_t b, input bit pick, input bit drain);
		plan_t p;
		p.beat           = b;
		p.pick_word      = pick;
		p.hold_for_drain = drain;
		stim_plan.push_back(p);
	endtask

	function automatic sppr_pkg::in_beat_t random_beat(input logic [1:0] act);
		sppr_pkg::in_beat_t b;
		b.action        = act;
		b.sample_first  = sample_value();
		b.sample_second = sample_value();
		b.read_slot     = 3'($urandom_range(0, 7));
		b.read_word     = 7'($urandom_range(0, 127));
		return b;
	endfunction

	task automatic plan_mix(input int n, input int ins_pct, input int done_pct,
			input int read_pct, input bit drain);
		int r;
		logic [1:0] act;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct) act = sppr_pkg::ACT_INSERT;
			else if (r < ins_pct + done_pct) act = sppr_pkg::ACT_DONE;
			else if (r < ins_pct + done_pct + read_pct) act = sppr_pkg::ACT_READ;
			else act = sppr_pkg::ACT_NOP;
			plan_beat(random_beat(act), act == sppr_pkg::ACT_READ, drain && i == 0);
		end
	endtask

	initial begin
		sppr_pkg::in_beat_t b;
		arst_n           = 1'b0;
		sample_in.valid  = 1'b0;
		sample_in.data   = '0;
		result_out.ready = 1'b0;
		head_q           = '0;
		tail_q           = '0;
		filled_q         = '0;
		fill_bytes       = 0;
		beats_sent       = 0;
		beats_checked    = 0;
		errors           = 0;
		send_gap         = 0;
		stall_left       = 0;
		idle_cycles      = 0;
		drive_idle_pct   = 4;
		sink_idle_pct    = 4;
		n_ack = 0; n_nak = 0; n_drop = 0; n_empty = 0; n_read = 0;

		// directed: done on an empty queue, no-ops with extreme fields
		plan_beat(random_beat(sppr_pkg::ACT_DONE), 1'b0, 1'b0);
		b = '1;
		plan_beat(b, 1'b0, 1'b0);
		b = '0;
		b.action = sppr_pkg::ACT_NOP;
		plan_beat(b, 1'b0, 1'b0);
		// directed: inserts with extreme samples
		b = '0;
		b.action = sppr_pkg::ACT_INSERT;
		plan_beat(b, 1'b0, 1'b0);
		b = '1;
		b.action = sppr_pkg::ACT_INSERT;
		plan_beat(b, 1'b0, 1'b0);
		b = random_beat(sppr_pkg::ACT_INSERT);
		b.sample_first  = 32'hAAAA_5555;
		b.sample_second = 32'h5555_AAAA;
		plan_beat(b, 1'b0, 1'b0);
		// directed: read back header, timestamp and the three pairs of slot 0
		for (int w = 0; w < 8; w++) begin
			b = random_beat(sppr_pkg::ACT_READ);
			b.read_slot = 3'd0;
			b.read_word = 7'(w);
			plan_beat(b, 1'b0, 1'b0);
		end
		plan_beat(random_beat(sppr_pkg::ACT_DONE), 1'b0, 1'b0);

		// mixed traffic, then enough dones to empty the queue
		plan_mix(20, 70, 10, 15, 1'b0);
		for (int i = 0; i < 10; i++) begin
			plan_beat(random_beat(sppr_pkg::ACT_DONE), 1'b0, 1'b0);
		end
		// fill the whole ring without transmits so packets get dropped
		for (int i = 0; i < 575; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				plan_beat(random_beat(sppr_pkg::ACT_READ), 1'b1, 1'b0);
			end
			plan_beat(random_beat(sppr_pkg::ACT_INSERT), 1'b0, i == 0);
		end
		// drain past empty, reading between transmits
		for (int i = 0; i < 12; i++) begin
			plan_beat(random_beat(sppr_pkg::ACT_DONE), 1'b0, 1'b0);
			plan_beat(random_beat(sppr_pkg::ACT_READ), 1'b1, 1'b0);
		end
		plan_mix(20, 60, 15, 20, 1'b1);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stim_plan.size() != 0 || sample_in.valid || beats_sent != beats_checked) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d expected result beats never arrived", due_results.size());
			errors++;
		end

		$display("run: %0d beats sent, %0d results checked, %0d errors",
			beats_sent, beats_checked, errors);
		$display("seen: %0d ACK, %0d NAK, %0d dropped, %0d done-on-empty, %0d nonzero reads",
			n_ack, n_nak, n_drop, n_empty, n_read);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
sv/sppr_pkg.sv
sv/sppr_in_if.sv
sv/sppr_out_if.sv
sv/sample_pair_packetizer_ring_top.sv
sim/sample_pair_packetizer_ring_top_tb.sv
